@@ rtl/point_cloud_pixel_colorizer_macros.svh @@
// Assertion macros shared by the colorizer RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef POINT_CLOUD_PIXEL_COLORIZER_MACROS_SVH
`define POINT_CLOUD_PIXEL_COLORIZER_MACROS_SVH

`ifndef SYNTHESIS
`define PCPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PCPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCPC_ASSERT(lbl, clk, rst, prop, msg)
`define PCPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/pcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpc_pkg
// Types, constants and the hue-to-color function of the pixel colorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpc_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 12;
  localparam int POS_W      = 32;
  localparam int INV_W      = 24;
  localparam int ORG_W      = 28;
  localparam int ORG_SH     = 24;
  localparam int FRAC_W     = 32;
  localparam int PROD_W     = POS_W + INV_W + 1;
  localparam int WIDE_W     = 60;
  localparam int COORD_W    = WIDE_W - FRAC_W;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  localparam int HUE_WRAP    = 360;
  localparam int SECTOR_SPAN = 60;
  localparam int CH_MAX      = 255;

  localparam logic [INV_W-1:0] INV_RES_RST  = INV_W'(1310720);
  localparam logic [ORG_W-1:0] ORIGIN_RST   = ORG_W'(2560);
  localparam logic [DIM_W-1:0] MAP_DIM_RST  = DIM_W'(4096);

  localparam logic [WIDE_W-1:0] ROUND_POS = WIDE_W'(64'h8000_0000);
  localparam logic [WIDE_W-1:0] ROUND_NEG = WIDE_W'(64'h7FFF_FFFF);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_RES    = 3'd0,
    REG_ORIGIN_X   = 3'd1,
    REG_ORIGIN_Y   = 3'd2,
    REG_IMG_WIDTH  = 3'd3,
    REG_IMG_HEIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic        [INV_W-1:0] inv_res;
    logic signed [ORG_W-1:0] origin_x;
    logic signed [ORG_W-1:0] origin_y;
    logic        [DIM_W-1:0] img_width;
    logic        [DIM_W-1:0] img_height;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    color_t                    color;
  } coord_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

  function automatic color_t hue_color(input logic [CH_W-1:0] inten);
    logic [8:0] dbl;
    logic [8:0] hue;
    logic [8:0] base;
    sector_t    sec;
    logic [5:0] rem;
    logic [9:0] r17;
    logic [9:0] r17_up;
    logic [CH_W-1:0] rise;
    logic [CH_W-1:0] fall;
    color_t     c;
    dbl = {inten, 1'b0};
    hue = (dbl >= 9'(HUE_WRAP)) ? dbl - 9'(HUE_WRAP) : dbl;
    if (hue >= 9'(5 * SECTOR_SPAN)) begin
      sec = SEC_M_TO_R; base = 9'(5 * SECTOR_SPAN);
    end else if (hue >= 9'(4 * SECTOR_SPAN)) begin
      sec = SEC_B_TO_M; base = 9'(4 * SECTOR_SPAN);
    end else if (hue >= 9'(3 * SECTOR_SPAN)) begin
      sec = SEC_C_TO_B; base = 9'(3 * SECTOR_SPAN);
    end else if (hue >= 9'(2 * SECTOR_SPAN)) begin
      sec = SEC_G_TO_C; base = 9'(2 * SECTOR_SPAN);
    end else if (hue >= 9'(SECTOR_SPAN)) begin
      sec = SEC_Y_TO_G; base = 9'(SECTOR_SPAN);
    end else begin
      sec = SEC_R_TO_Y; base = 9'd0;
    end
    rem    = 6'(hue - base);
    r17    = {rem, 4'b0000} + {4'b0000, rem};
    r17_up = r17 + 10'd3;
    rise   = CH_W'(r17 >> 2);
    fall   = CH_W'(CH_MAX) - CH_W'(r17_up >> 2);
    case (sec)
      SEC_R_TO_Y: begin c.red = CH_W'(CH_MAX); c.green = rise;           c.blue = '0; end
      SEC_Y_TO_G: begin c.red = fall;          c.green = CH_W'(CH_MAX);  c.blue = '0; end
      SEC_G_TO_C: begin c.red = '0;            c.green = CH_W'(CH_MAX);  c.blue = rise; end
      SEC_C_TO_B: begin c.red = '0;            c.green = fall;  c.blue = CH_W'(CH_MAX); end
      SEC_B_TO_M: begin c.red = rise;          c.green = '0;    c.blue = CH_W'(CH_MAX); end
      default:    begin c.red = CH_W'(CH_MAX); c.green = '0;    c.blue = fall; end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pcpc_cfg.sv @@
// ----------------------------------------------------------------------------
// pcpc_cfg
// Configuration register file: scale, map origin and map size.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpc_cfg
  import pcpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_res    <= INV_RES_RST;
      cfg.origin_x   <= ORIGIN_RST;
      cfg.origin_y   <= ORIGIN_RST;
      cfg.img_width  <= MAP_DIM_RST;
      cfg.img_height <= MAP_DIM_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_INV_RES:    cfg.inv_res    <= wr_data[INV_W-1:0];
        REG_ORIGIN_X:   cfg.origin_x   <= $signed(wr_data[ORG_W-1:0]);
        REG_ORIGIN_Y:   cfg.origin_y   <= $signed(wr_data[ORG_W-1:0]);
        REG_IMG_WIDTH:  cfg.img_width  <= wr_data[DIM_W-1:0];
        REG_IMG_HEIGHT: cfg.img_height <= wr_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/pcpc_project.sv @@
// ----------------------------------------------------------------------------
// pcpc_project
// Three-stage projection pipe: scale, offset, round to pixel coordinates.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_cloud_pixel_colorizer_macros.svh"

module pcpc_project
  import pcpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    cfg,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic [CH_W-1:0]         intensity,
  output logic                         s3_valid,
  input  wire logic                    s3_ready,
  output coord_t                       s3
);

  logic v1, v2;
  logic ready1, ready2, ready3;

  logic signed [PROD_W-1:0] prod_x, prod_y;
  color_t                   color1, color2;
  logic signed [WIDE_W-1:0] sx, rowv;
  logic signed [WIDE_W-1:0] sx_rnd, rowv_rnd;
  logic signed [WIDE_W-1:0] hgt_q;

  assign ready3   = !s3_valid || s3_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  assign hgt_q    = $signed(WIDE_W'({cfg.img_height, FRAC_W'(0)}));
  assign sx_rnd   = sx + $signed(sx[WIDE_W-1] ? ROUND_NEG : ROUND_POS);
  assign rowv_rnd = rowv + $signed(rowv[WIDE_W-1] ? ROUND_NEG : ROUND_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        s3_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      prod_x <= pos_x * $signed({1'b0, cfg.inv_res});
      prod_y <= pos_y * $signed({1'b0, cfg.inv_res});
      color1 <= hue_color(intensity);
    end
    if (ready2 && v1) begin
      sx     <= WIDE_W'(prod_x) + (WIDE_W'(cfg.origin_x) <<< ORG_SH);
      rowv   <= hgt_q - WIDE_W'(prod_y) - (WIDE_W'(cfg.origin_y) <<< ORG_SH);
      color2 <= color1;
    end
    if (ready3 && v2) begin
      s3.col   <= sx_rnd[WIDE_W-1:FRAC_W];
      s3.row   <= rowv_rnd[WIDE_W-1:FRAC_W];
      s3.color <= color2;
    end
  end

  `PCPC_ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && !in_stall, v1, "transaction not taken")
  `PCPC_ASSERT(a_stall_full, clk, rst, !in_stall || (v1 && v2 && s3_valid), "stall, free stage")
  `PCPC_ASSERT_NEXT(a_hold, clk, rst, s3_valid && !s3_ready, s3_valid && $stable(s3), "hold lost")

endmodule

`default_nettype wire

@@ rtl/pcpc_place.sv @@
// ----------------------------------------------------------------------------
// pcpc_place
// Map bounds check and output register; drops points off the map.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_cloud_pixel_colorizer_macros.svh"

module pcpc_place
  import pcpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic             s3_valid,
  output logic                  s3_ready,
  input  wire coord_t           s3,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [PIX_W-1:0]      pixel_col,
  output logic [PIX_W-1:0]      pixel_row,
  output logic [CH_W-1:0]       blue,
  output logic [CH_W-1:0]       green,
  output logic [CH_W-1:0]       red
);

  logic [DIM_W-1:0] width_lim, height_lim;
  logic             col_ok, row_ok, hit;

  assign width_lim  = clamp_dim(cfg.img_width);
  assign height_lim = clamp_dim(cfg.img_height);
  assign col_ok = !s3.col[COORD_W-1] &&
                  (s3.col[COORD_W-2:0] < (COORD_W-1)'(width_lim));
  assign row_ok = !s3.row[COORD_W-1] &&
                  (s3.row[COORD_W-2:0] < (COORD_W-1)'(height_lim));
  assign hit      = col_ok && row_ok;
  assign s3_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s3_valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      pixel_col <= s3.col[PIX_W-1:0];
      pixel_row <= s3.row[PIX_W-1:0];
      blue      <= s3.color.blue;
      green     <= s3.color.green;
      red       <= s3.color.red;
    end
  end

  `PCPC_ASSERT_NEXT(a_hit_delivers, clk, rst, s3_valid && s3_ready && hit, out_valid, "hit lost")
  `PCPC_ASSERT_NEXT(a_miss_drops, clk, rst, s3_valid && s3_ready && !hit, !out_valid, "miss shown")

endmodule

`default_nettype wire

@@ rtl/point_cloud_pixel_colorizer.sv @@
// A point passes four register stages on its way to its pixel: scale, offset,
// round, bounds check. Throughput: one point per cycle while out_stall is low;
// a stage takes a new point each cycle unless it is full and held by a stall.
// Points that land off the map are dropped in the last stage and give no output.
// Reset (synchronous): pipeline emptied, registers back to 20 px/m, origin 10.0,
// map 4096 x 4096.
// ----------------------------------------------------------------------------
// point_cloud_pixel_colorizer
// Projects map-frame lidar points to grid pixels and colors them by intensity.
// ----------------------------------------------------------------------------
`default_nettype none

module point_cloud_pixel_colorizer
  import pcpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [CFG_IDX_W-1:0]    wr_index,
  input  wire logic [CFG_DATA_W-1:0]   wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic [CH_W-1:0]         intensity,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [PIX_W-1:0]             pixel_col,
  output logic [PIX_W-1:0]             pixel_row,
  output logic [CH_W-1:0]              blue,
  output logic [CH_W-1:0]              green,
  output logic [CH_W-1:0]              red
);

  cfg_t   cfg;
  logic   s3_valid, s3_ready;
  coord_t s3;

  pcpc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  pcpc_project u_project (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .intensity (intensity),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3        (s3)
  );

  pcpc_place u_place (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3        (s3),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .blue      (blue),
    .green     (green),
    .red       (red)
  );

endmodule

`default_nettype wire
